[src/twodom_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodom_pkg
// Shared types, constants and tables of the three wheel odometry core.
// ----------------------------------------------------------------------------
package twodom_pkg;

    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] DPC_RESET   = 32'd402627;
    localparam logic [30:0] LOFF_RESET  = 31'd458752;
    localparam logic [30:0] ROFF_RESET  = 31'd458752;
    localparam logic [30:0] BOFF_RESET  = 31'd327680;

    // Configuration register indexes
    localparam logic [1:0] CFG_DPC  = 2'd0;
    localparam logic [1:0] CFG_LOFF = 2'd1;
    localparam logic [1:0] CFG_ROFF = 2'd2;
    localparam logic [1:0] CFG_BOFF = 2'd3;

    // Rounding right shifts, plus a plain truncating shift for reciprocal divides
    typedef enum logic [2:0] {RND_8, RND_29, RND_30, RND_31, TRUNC_39} rnd_sel_t;

    typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_HI, MP_RND} mul_phase_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DL, S_DR, S_DB, S_DEN, S_DTH, S_DDIV, S_RAD, S_U,
        S_HMUL, S_HDIV, S_T1, S_H, S_T2, S_H2, S_ROT,
        S_M1, S_M2, S_M3, S_M4, S_SAT, S_PUT
    } seq_state_t;

    typedef struct packed {
        logic        start;
        logic        neg;
        rnd_sel_t    rnd;
        logic [63:0] ma;
        logic [32:0] mb;
    } mul_cmd_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [34:0] rem0;
        logic [31:0] dvd;
        logic [34:0] dsr;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cord_cmd_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] sn;
        logic signed [33:0] cs;
    } cord_rsp_t;

    function automatic logic [5:0] rnd_shift(input rnd_sel_t sel);
        logic [5:0] s;
        unique case (sel)
            RND_8:    s = 6'd8;
            RND_29:   s = 6'd29;
            RND_30:   s = 6'd30;
            RND_31:   s = 6'd31;
            TRUNC_39: s = 6'd39;
            default:  s = 6'd8;
        endcase
        return s;
    endfunction

    // Divisors of the sine series steps, highest term first
    function automatic logic [6:0] horner_div(input logic [2:0] idx);
        logic [6:0] d;
        case (idx)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // ceil(2^39 / d) for the same divisors; exact floor division of any
    // 32-bit dividend after a truncating shift by 39
    function automatic logic [36:0] horner_recip(input logic [2:0] idx);
        logic [36:0] m;
        case (idx)
            3'd0:    m = 37'd4997780127;
            3'd1:    m = 37'd7635497416;
            3'd2:    m = 37'd13089424141;
            3'd3:    m = 37'd27487790695;
            default: m = 37'd91625968982;
        endcase
        return m;
    endfunction

    // atan(2^-i) as a binary angle
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517C;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A2F;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028B;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000A2;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000028;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000002;
            5'd29:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

[src/three_wheel_odometry_pose_update_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wheel_odometry_pose_update_core
// Pose update from left, right and back tracking wheel count deltas.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one item: mode 0 updates the pose from the three count
//   deltas, mode 1 loads x, y and heading. Every item yields one item on the
//   m_* channel with the new pose (Q16.16 x/y, binary angle heading).
//   The cfg_* port writes distance_per_count and the three wheel offsets;
//   write only while the core is idle.
// Sequencing:
//   A load item goes from accept straight to S_PUT, which sets m_valid.
//   An update item runs through a shared 64x33 multiplier (24 products;
//   the five sine-series divides are reciprocal multiplies), a 32-step
//   restoring divider for the heading change (skipped when that change is
//   zero or saturated) and an iterative CORDIC, then S_SAT and S_PUT.
//   S_PUT sets m_valid once the output register is free, and the core is
//   back in idle as m_valid rises. s_ready is high only while idle.
// Reset: clears the pose to zero and loads the register defaults.
// Stall: the result sits in the output register until m_ready; the core can
//   take and work the next item meanwhile and holds before delivering it.
// ----------------------------------------------------------------------------
module three_wheel_odometry_pose_update_core
    import twodom_pkg::*;
#(
    parameter int COUNT_BITS   = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    // input items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic signed [COUNT_BITS-1:0] s_left_count,
    input  logic signed [COUNT_BITS-1:0] s_right_count,
    input  logic signed [COUNT_BITS-1:0] s_back_count,
    input  logic signed [31:0]           s_load_x,
    input  logic signed [31:0]           s_load_y,
    input  logic [31:0]                  s_load_heading,
    // result items
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_pos_x,
    output logic signed [31:0]           m_pos_y,
    output logic [31:0]                  m_pos_heading
);

    // Signed width of a scaled wheel distance
    localparam int D_W = COUNT_BITS + 25;

    seq_state_t state_reg, state_next;
    logic       issued_reg;

    // configuration
    logic [31:0] dpc_reg;
    logic [30:0] loff_reg, roff_reg, boff_reg;

    // pose
    logic signed [31:0] x_acc_reg, y_acc_reg;
    logic [31:0]        hd_acc_reg;

    // captured counts
    logic signed [COUNT_BITS-1:0] lc_reg, rc_reg, bc_reg;

    // intermediate values
    logic signed [D_W-1:0] dl_reg, dr_reg, db_reg;
    logic [34:0]           den_reg;
    logic signed [31:0]    dth_reg;
    logic signed [32:0]    rad_reg;
    logic [31:0]           u_reg, p_reg;
    logic [30:0]           k_reg;
    logic [2:0]            hp_idx_reg;
    logic signed [63:0]    t_reg, h_reg, h2_reg;
    logic signed [63:0]    x_sum_reg, y_sum_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] m_x_reg, m_y_reg;
    logic [31:0]        m_hd_reg;

    mul_cmd_t  mul_cmd;
    mul_rsp_t  mul_rsp;
    div_cmd_t  div_cmd;
    div_rsp_t  div_rsp;
    cord_cmd_t cord_cmd;
    cord_rsp_t cord_rsp;

    // derived magnitudes
    logic [COUNT_BITS-1:0] lc_mag, rc_mag, bc_mag;
    logic signed [D_W:0]   diff;
    logic                  diff_neg;
    logic [D_W:0]          a_mag;
    logic                  a_zero, a_sat;
    logic [31:0]           q_sat;
    logic                  dth_neg;
    logic [31:0]           dth_mag;
    logic [32:0]           dhalf_sum;
    logic [31:0]           dhalf;
    logic                  rad_neg;
    logic [32:0]           rad_mag;
    logic [32:0]           half_sum;
    logic [31:0]           half_mag;
    logic signed [63:0]    sum1, sum2;
    logic [63:0]           sum1_mag, sum2_mag, h_mag, h2_mag;
    logic [33:0]           sn_abs, cs_abs;
    logic                  put_ok;
    logic [6:0]            hdiv;

    assign lc_mag = lc_reg[COUNT_BITS-1] ? (~lc_reg + 1'b1) : lc_reg;
    assign rc_mag = rc_reg[COUNT_BITS-1] ? (~rc_reg + 1'b1) : rc_reg;
    assign bc_mag = bc_reg[COUNT_BITS-1] ? (~bc_reg + 1'b1) : bc_reg;

    assign diff     = (D_W+1)'(dl_reg) - (D_W+1)'(dr_reg);
    assign diff_neg = diff[D_W];
    assign a_mag    = diff_neg ? (~diff + 1'b1) : diff;
    assign a_zero   = (a_mag == '0);
    assign a_sat    = {a_mag, 1'b0} >= (D_W+2)'(den_reg);
    assign q_sat    = 32'h7FFFFFFF;

    assign dth_neg   = dth_reg[31];
    assign dth_mag   = dth_neg ? (~dth_reg + 1'b1) : dth_reg;
    assign dhalf_sum = {1'b0, dth_mag} + 33'd1;
    assign dhalf     = dth_neg ? (~dhalf_sum[32:1] + 1'b1) : dhalf_sum[32:1];

    assign rad_neg  = rad_reg[32];
    assign rad_mag  = rad_neg ? (~rad_reg + 1'b1) : rad_reg;
    assign half_sum = {1'b0, rad_mag[31:0]} + 33'd1;
    assign half_mag = half_sum[32:1];

    assign sum1     = 64'(dr_reg) + t_reg;
    assign sum2     = 64'(db_reg) + t_reg;
    assign sum1_mag = sum1[63] ? (~sum1 + 1'b1) : sum1;
    assign sum2_mag = sum2[63] ? (~sum2 + 1'b1) : sum2;
    assign h_mag    = h_reg[63] ? (~h_reg + 1'b1) : h_reg;
    assign h2_mag   = h2_reg[63] ? (~h2_reg + 1'b1) : h2_reg;
    assign sn_abs   = cord_rsp.sn[33] ? (~cord_rsp.sn + 1'b1) : cord_rsp.sn;
    assign cs_abs   = cord_rsp.cs[33] ? (~cord_rsp.cs + 1'b1) : cord_rsp.cs;

    assign hdiv   = horner_div(hp_idx_reg);
    assign put_ok = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = s_mode ? S_PUT : S_DL;
            S_DL:    if (mul_rsp.done) state_next = S_DR;
            S_DR:    if (mul_rsp.done) state_next = S_DB;
            S_DB:    if (mul_rsp.done) state_next = S_DEN;
            S_DEN:   if (mul_rsp.done) state_next = S_DTH;
            S_DTH:   state_next = (a_zero || a_sat) ? S_RAD : S_DDIV;
            S_DDIV:  if (div_rsp.done) state_next = S_RAD;
            S_RAD:   if (mul_rsp.done) state_next = S_U;
            S_U:     if (mul_rsp.done) state_next = S_HMUL;
            S_HMUL:  if (mul_rsp.done) state_next = S_HDIV;
            S_HDIV: begin
                if (mul_rsp.done) state_next = (hp_idx_reg == 3'd4) ? S_T1 : S_HMUL;
            end
            S_T1:    if (mul_rsp.done) state_next = S_H;
            S_H:     if (mul_rsp.done) state_next = S_T2;
            S_T2:    if (mul_rsp.done) state_next = S_H2;
            S_H2:    if (mul_rsp.done) state_next = S_ROT;
            S_ROT:   if (cord_rsp.done) state_next = S_M1;
            S_M1:    if (mul_rsp.done) state_next = S_M2;
            S_M2:    if (mul_rsp.done) state_next = S_M3;
            S_M3:    if (mul_rsp.done) state_next = S_M4;
            S_M4:    if (mul_rsp.done) state_next = S_SAT;
            S_SAT:   state_next = S_PUT;
            S_PUT:   if (put_ok) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: unit commands
    // ------------------------------------------------------------------
    always_comb begin
        s_ready        = 1'b0;
        mul_cmd        = '0;
        mul_cmd.rnd    = RND_30;
        div_cmd        = '0;
        cord_cmd       = '0;
        cord_cmd.angle = hd_acc_reg + dhalf;
        unique case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_DL: begin
                mul_cmd.ma  = 64'(lc_mag);
                mul_cmd.mb  = {1'b0, dpc_reg};
                mul_cmd.rnd = RND_8;
                mul_cmd.neg = !lc_reg[COUNT_BITS-1];
            end
            S_DR: begin
                mul_cmd.ma  = 64'(rc_mag);
                mul_cmd.mb  = {1'b0, dpc_reg};
                mul_cmd.rnd = RND_8;
                mul_cmd.neg = rc_reg[COUNT_BITS-1];
            end
            S_DB: begin
                mul_cmd.ma  = 64'(bc_mag);
                mul_cmd.mb  = {1'b0, dpc_reg};
                mul_cmd.rnd = RND_8;
                mul_cmd.neg = !bc_reg[COUNT_BITS-1];
            end
            S_DEN: begin
                mul_cmd.ma  = 64'({1'b0, loff_reg} + {1'b0, roff_reg});
                mul_cmd.mb  = {1'b0, TWO_PI_Q29};
                mul_cmd.rnd = RND_29;
            end
            S_DTH: begin
                div_cmd.start = !(a_zero || a_sat);
                div_cmd.rem0  = 35'(a_mag);
                div_cmd.dvd   = '0;
                div_cmd.dsr   = den_reg;
            end
            S_RAD: begin
                mul_cmd.ma  = 64'(dth_mag);
                mul_cmd.mb  = {1'b0, TWO_PI_Q29};
                mul_cmd.rnd = RND_31;
                mul_cmd.neg = dth_neg;
            end
            S_U: begin
                mul_cmd.ma = 64'(half_mag);
                mul_cmd.mb = {1'b0, half_mag};
            end
            S_HMUL: begin
                mul_cmd.ma = 64'(u_reg);
                mul_cmd.mb = 33'(k_reg);
            end
            // rounded divide by the series constant: add half the divisor,
            // multiply by its reciprocal and drop 39 bits
            S_HDIV: begin
                mul_cmd.ma  = 64'(horner_recip(hp_idx_reg));
                mul_cmd.mb  = {1'b0, p_reg + 32'(hdiv >> 1)};
                mul_cmd.rnd = TRUNC_39;
            end
            S_T1: begin
                mul_cmd.ma  = 64'(roff_reg);
                mul_cmd.mb  = rad_mag;
                mul_cmd.neg = rad_neg;
            end
            S_H: begin
                mul_cmd.ma  = sum1_mag;
                mul_cmd.mb  = 33'(k_reg);
                mul_cmd.neg = sum1[63];
            end
            S_T2: begin
                mul_cmd.ma  = 64'(boff_reg);
                mul_cmd.mb  = rad_mag;
                mul_cmd.neg = rad_neg;
            end
            S_H2: begin
                mul_cmd.ma  = sum2_mag;
                mul_cmd.mb  = 33'(k_reg);
                mul_cmd.neg = sum2[63];
            end
            S_ROT: cord_cmd.start = !issued_reg;
            S_M1: begin
                mul_cmd.ma  = h_mag;
                mul_cmd.mb  = sn_abs[32:0];
                mul_cmd.neg = h_reg[63] ^ cord_rsp.sn[33];
            end
            S_M2: begin
                mul_cmd.ma  = h2_mag;
                mul_cmd.mb  = cs_abs[32:0];
                mul_cmd.neg = h2_reg[63] ^ cord_rsp.cs[33];
            end
            S_M3: begin
                mul_cmd.ma  = h_mag;
                mul_cmd.mb  = cs_abs[32:0];
                mul_cmd.neg = h_reg[63] ^ cord_rsp.cs[33];
            end
            S_M4: begin
                mul_cmd.ma  = h2_mag;
                mul_cmd.mb  = sn_abs[32:0];
                mul_cmd.neg = h2_reg[63] ^ cord_rsp.sn[33];
            end
            default: ;
        endcase
        // issue a product once on entry to each multiply step
        unique case (state_reg)
            S_DL, S_DR, S_DB, S_DEN, S_RAD, S_U, S_HMUL, S_HDIV, S_T1, S_H, S_T2,
            S_H2, S_M1, S_M2, S_M3, S_M4: mul_cmd.start = !issued_reg;
            default: mul_cmd.start = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            dpc_reg     <= DPC_RESET;
            loff_reg    <= LOFF_RESET;
            roff_reg    <= ROFF_RESET;
            boff_reg    <= BOFF_RESET;
            x_acc_reg   <= '0;
            y_acc_reg   <= '0;
            hd_acc_reg  <= '0;
        end else begin
            state_reg <= state_next;

            if (mul_rsp.done || div_rsp.done || cord_rsp.done) begin
                issued_reg <= 1'b0;
            end else if (mul_cmd.start || cord_cmd.start) begin
                issued_reg <= 1'b1;
            end

            if (state_reg == S_PUT && put_ok) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_DPC:  dpc_reg  <= cfg_data;
                    CFG_LOFF: loff_reg <= cfg_data[30:0];
                    CFG_ROFF: roff_reg <= cfg_data[30:0];
                    CFG_BOFF: boff_reg <= cfg_data[30:0];
                    default:  ;
                endcase
            end

            // load mode sets the pose on accept
            if (state_reg == S_IDLE && s_valid && s_mode) begin
                x_acc_reg  <= s_load_x;
                y_acc_reg  <= s_load_y;
                hd_acc_reg <= s_load_heading;
            end

            // saturate positions, wrap heading
            if (state_reg == S_SAT) begin
                if (x_sum_reg > 64'sd2147483647) x_acc_reg <= 32'sh7FFFFFFF;
                else if (x_sum_reg < -64'sd2147483648) x_acc_reg <= 32'sh80000000;
                else x_acc_reg <= x_sum_reg[31:0];
                if (y_sum_reg > 64'sd2147483647) y_acc_reg <= 32'sh7FFFFFFF;
                else if (y_sum_reg < -64'sd2147483648) y_acc_reg <= 32'sh80000000;
                else y_acc_reg <= y_sum_reg[31:0];
                hd_acc_reg <= hd_acc_reg + dth_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            lc_reg <= s_left_count;
            rc_reg <= s_right_count;
            bc_reg <= s_back_count;
        end
        if (state_reg == S_PUT && put_ok) begin
            m_x_reg  <= x_acc_reg;
            m_y_reg  <= y_acc_reg;
            m_hd_reg <= hd_acc_reg;
        end
        if (state_reg == S_DTH) begin
            if (a_zero) dth_reg <= '0;
            else if (a_sat) dth_reg <= diff_neg ? (~q_sat + 1'b1) : q_sat;
        end
        if (state_reg == S_DDIV && div_rsp.done) begin
            dth_reg <= diff_neg ? (~div_rsp.quo + 1'b1) : div_rsp.quo;
        end
        if (state_reg == S_U && mul_rsp.done) begin
            k_reg      <= ONE_Q30;
            hp_idx_reg <= '0;
        end
        if (state_reg == S_HDIV && mul_rsp.done) begin
            k_reg      <= ONE_Q30 - mul_rsp.res[30:0];
            hp_idx_reg <= hp_idx_reg + 3'd1;
        end
        if (mul_rsp.done) begin
            case (state_reg)
                S_DL:    dl_reg    <= D_W'(mul_rsp.res);
                S_DR:    dr_reg    <= D_W'(mul_rsp.res);
                S_DB:    db_reg    <= D_W'(mul_rsp.res);
                S_DEN:   den_reg   <= mul_rsp.res[34:0];
                S_RAD:   rad_reg   <= mul_rsp.res[32:0];
                S_U:     u_reg     <= mul_rsp.res[31:0];
                S_HMUL:  p_reg     <= mul_rsp.res[31:0];
                S_T1:    t_reg     <= mul_rsp.res;
                S_H:     h_reg     <= mul_rsp.res;
                S_T2:    t_reg     <= mul_rsp.res;
                S_H2:    h2_reg    <= mul_rsp.res;
                S_M1:    x_sum_reg <= 64'(x_acc_reg) + mul_rsp.res;
                S_M2:    x_sum_reg <= x_sum_reg + mul_rsp.res;
                S_M3:    y_sum_reg <= 64'(y_acc_reg) + mul_rsp.res;
                S_M4:    y_sum_reg <= y_sum_reg - mul_rsp.res;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    twodom_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .rsp     (mul_rsp)
    );

    twodom_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .rsp     (div_rsp)
    );

    twodom_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cord_cmd),
        .rsp     (cord_rsp)
    );

    assign m_valid       = m_valid_reg;
    assign m_pos_x       = m_x_reg;
    assign m_pos_y       = m_y_reg;
    assign m_pos_heading = m_hd_reg;

endmodule

[src/twodom_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodom_mul
// Shared multiplier: 64 x 33 bit magnitude product in two 32-bit halves,
// then a rounding (or truncating) right shift and the sign.
// ----------------------------------------------------------------------------
module twodom_mul
    import twodom_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_cmd_t cmd,
    output mul_rsp_t rsp
);

    mul_phase_t   phase_reg, phase_next;
    logic [63:0]  ma_reg;
    logic [32:0]  mb_reg;
    logic         neg_reg;
    rnd_sel_t     rnd_reg;
    logic [96:0]  acc_reg;
    logic         done_reg;
    logic signed [63:0] res_reg;

    logic [31:0]  ma_half;
    logic [64:0]  pp;
    logic [5:0]   shamt;
    logic [96:0]  rbias;
    logic [96:0]  rsum;
    logic [96:0]  shifted;
    logic [63:0]  mag;

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MP_IDLE: if (cmd.start) phase_next = MP_LO;
            MP_LO:   phase_next = MP_HI;
            MP_HI:   phase_next = MP_RND;
            MP_RND:  phase_next = MP_IDLE;
            default: phase_next = MP_IDLE;
        endcase
    end

    assign ma_half = (phase_reg == MP_LO) ? ma_reg[31:0] : ma_reg[63:32];
    assign pp      = ma_half * mb_reg;
    assign shamt   = rnd_shift(rnd_reg);
    assign rbias   = (rnd_reg == TRUNC_39) ? '0 : ((97'd1 << shamt) >> 1);
    assign rsum    = acc_reg + rbias;
    assign shifted = rsum >> shamt;
    assign mag     = shifted[63:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == MP_RND);
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == MP_IDLE && cmd.start) begin
            ma_reg  <= cmd.ma;
            mb_reg  <= cmd.mb;
            neg_reg <= cmd.neg;
            rnd_reg <= cmd.rnd;
        end
        case (phase_reg)
            MP_LO:   acc_reg <= {32'd0, pp};
            MP_HI:   acc_reg <= acc_reg + {pp, 32'd0};
            MP_RND:  res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
            default: ;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

[src/twodom_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodom_div
// Restoring divider, one quotient bit per cycle, 32 bits.
// ----------------------------------------------------------------------------
module twodom_div
    import twodom_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_cmd_t cmd,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [34:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [34:0] dsr_reg;
    logic [31:0] quo_reg;

    logic [35:0] rs;
    logic        ge;
    logic [35:0] rn;

    assign rs = {rem_reg, dvd_reg[31]};
    assign ge = rs >= {1'b0, dsr_reg};
    assign rn = ge ? (rs - {1'b0, dsr_reg}) : rs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && cmd.start) begin
            rem_reg <= cmd.rem0;
            dvd_reg <= cmd.dvd;
            dsr_reg <= cmd.dsr;
        end else if (busy_reg) begin
            rem_reg <= rn[34:0];
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

[src/twodom_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodom_cordic
// Iterative CORDIC rotator: sine and cosine (Q1.30) of a binary angle.
// ----------------------------------------------------------------------------
module twodom_cordic
    import twodom_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cord_cmd_t cmd,
    output cord_rsp_t rsp
);

    localparam int CNT_W = $clog2(STEPS);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               flip_reg;

    logic signed [33:0] z0, z_fold;
    logic               flip;
    logic [4:0]         idx;
    logic signed [33:0] xs, ys, at;

    always_comb begin
        z0     = 34'($signed(cmd.angle));
        z_fold = z0;
        flip   = 1'b0;
        if (z0 > 34'sd1073741824) begin
            z_fold = z0 - 34'sd2147483648;
            flip   = 1'b1;
        end else if (z0 < -34'sd1073741824) begin
            z_fold = z0 + 34'sd2147483648;
            flip   = 1'b1;
        end
    end

    assign idx = 5'(cnt_reg);
    assign xs  = x_reg >>> idx;
    assign ys  = y_reg >>> idx;
    assign at  = $signed({2'b00, atan_bam(idx)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && cmd.start) begin
            x_reg    <= GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= z_fold;
            flip_reg <= flip;
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sn   = flip_reg ? -y_reg : y_reg;
    assign rsp.cs   = flip_reg ? -x_reg : x_reg;

endmodule

[tb/sv/three_wheel_odometry_pose_update_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wheel_odometry_pose_update_core_tb
// Self-checking bench for the pose update core. Every accepted item is run
// through a bit-exact pose predictor, and each result item is compared with
// the oldest predicted pose. The run covers directed edge cases, then random
// count deltas and pose loads under several register settings and several
// sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module three_wheel_odometry_pose_update_core_tb;
    import twodom_pkg::*;

    localparam int     COUNT_BITS  = 16;
    localparam int     ARC_STEPS   = 24;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] ph;
    } pose_t;

    // ------------------------------------------------------------------------
    // Pose tracker: holds its own pose and register copies, predicts the pose
    // after each accepted item and checks result items against it.
    // ------------------------------------------------------------------------
    class pose_scoreboard;
        longint      x_acc;
        longint      y_acc;
        logic [31:0] head_acc;
        logic [31:0] dpc;
        logic [30:0] loff;
        logic [30:0] roff;
        logic [30:0] boff;
        pose_t       poses_due[$];
        int          n_taken;
        int          n_checked;
        int          n_errors;
        int          n_loads;
        int          n_sat_turns;

        function new();
            x_acc = 0;
            y_acc = 0;
            head_acc = 0;
            dpc  = DPC_RESET;
            loff = LOFF_RESET;
            roff = ROFF_RESET;
            boff = BOFF_RESET;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_DPC:  dpc  = val;
                CFG_LOFF: loff = val[30:0];
                CFG_ROFF: roff = val[30:0];
                CFG_BOFF: boff = val[30:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] mag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        // round to nearest, ties away from zero
        function longint round_shift(longint v, int s);
            logic [63:0] m;
            m = (mag(v) + (64'd1 << (s - 1))) >> s;
            return v < 0 ? -longint'(m) : longint'(m);
        endfunction

        function longint mul_q30(longint a, longint b);
            logic [63:0] ma;
            logic [63:0] mb;
            logic [63:0] r;
            ma = mag(a);
            mb = mag(b);
            r = (ma >> 30) * mb + (((ma & 64'h3FFF_FFFF) * mb + 64'h2000_0000) >> 30);
            return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void sin_cos(logic [31:0] ang, output longint sn, output longint cs);
            logic [31:0] arc_tab [24];
            longint z;
            longint cx;
            longint cy;
            longint nx;
            bit     flip;
            arc_tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
                        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
            z = ang[31] ? longint'(ang) - (64'sd1 <<< 32) : longint'(ang);
            cx = 652032874;
            cy = 0;
            flip = 0;
            // fold the back half plane onto the front one
            if (z > (64'sd1 <<< 30)) begin
                z -= 64'sd1 <<< 31;
                flip = 1;
            end else if (z < -(64'sd1 <<< 30)) begin
                z += 64'sd1 <<< 31;
                flip = 1;
            end
            for (int i = 0; i < ARC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = cx - (cy >>> i);
                    cy = cy + (cx >>> i);
                    z -= longint'(arc_tab[i]);
                end else begin
                    nx = cx + (cy >>> i);
                    cy = cy - (cx >>> i);
                    z += longint'(arc_tab[i]);
                end
                cx = nx;
            end
            cs = flip ? -cx : cx;
            sn = flip ? -cy : cy;
        endfunction

        function void note_item(logic mode, logic signed [COUNT_BITS-1:0] lc,
                                logic signed [COUNT_BITS-1:0] rc,
                                logic signed [COUNT_BITS-1:0] bc,
                                logic [31:0] lx, logic [31:0] ly, logic [31:0] lh);
            longint      dl, dr, db, diff, dth, rad, half, h, h2, sn, cs;
            logic [63:0] a, sum, den, q, r, u, k, p;
            logic [63:0] divs [5];
            pose_t       e;
            divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
            n_taken++;
            if (mode) begin
                n_loads++;
                x_acc = longint'(signed'(lx));
                y_acc = longint'(signed'(ly));
                head_acc = lh;
            end else begin
                dl = -round_shift(longint'(lc) * longint'(dpc), 8);
                dr = round_shift(longint'(rc) * longint'(dpc), 8);
                db = -round_shift(longint'(bc) * longint'(dpc), 8);
                diff = dl - dr;
                a = mag(diff);
                sum = 64'(loff) + 64'(roff);
                den = (sum * 64'd3373259426 + (64'd1 << 28)) >> 29;
                q = 0;
                if (a == 0) begin
                    q = 0;
                end else if (2 * a >= den) begin
                    q = 64'h7FFF_FFFF;
                    n_sat_turns++;
                end else begin
                    r = a;
                    for (int i = 0; i < 32; i++) begin
                        r = r << 1;
                        q = q << 1;
                        if (r >= den) begin
                            r -= den;
                            q |= 1;
                        end
                    end
                end
                dth = diff < 0 ? -longint'(q) : longint'(q);
                rad = round_shift(dth * 64'sd3373259426, 31);
                half = round_shift(rad, 1);
                u = (mag(half) * mag(half) + (64'd1 << 29)) >> 30;
                k = 64'd1 << 30;
                for (int i = 0; i < 5; i++) begin
                    p = (u * k + (64'd1 << 29)) >> 30;
                    p = (p + divs[i] / 2) / divs[i];
                    k = (64'd1 << 30) - p;
                end
                h  = mul_q30(dr + mul_q30(longint'(roff), rad), longint'(k));
                h2 = mul_q30(db + mul_q30(longint'(boff), rad), longint'(k));
                sin_cos(head_acc + 32'(round_shift(dth, 1)), sn, cs);
                x_acc = clamp32(x_acc + mul_q30(h, sn) + mul_q30(h2, cs));
                y_acc = clamp32(y_acc + mul_q30(h, cs) - mul_q30(h2, sn));
                head_acc = head_acc + 32'(dth);
            end
            e.px = 32'(x_acc);
            e.py = 32'(y_acc);
            e.ph = head_acc;
            poses_due.push_back(e);
        endfunction

        function void check_pose(logic [31:0] gx, logic [31:0] gy, logic [31:0] gh);
            pose_t e;
            if (poses_due.size() == 0) begin
                $display("%0t: unexpected result item x=%h y=%h heading=%h",
                         $time, gx, gy, gh);
                n_errors++;
                return;
            end
            e = poses_due.pop_front();
            n_checked++;
            if (gx !== e.px) begin
                $display("%0t: pos_x expected %h actual %h", $time, e.px, gx);
                n_errors++;
            end
            if (gy !== e.py) begin
                $display("%0t: pos_y expected %h actual %h", $time, e.py, gy);
                n_errors++;
            end
            if (gh !== e.ph) begin
                $display("%0t: pos_heading expected %h actual %h", $time, e.ph, gh);
                n_errors++;
            end
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_we;
    logic [1:0]                   cfg_index;
    logic [31:0]                  cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic                         s_mode;
    logic signed [COUNT_BITS-1:0] s_left_count;
    logic signed [COUNT_BITS-1:0] s_right_count;
    logic signed [COUNT_BITS-1:0] s_back_count;
    logic signed [31:0]           s_load_x;
    logic signed [31:0]           s_load_y;
    logic [31:0]                  s_load_heading;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [31:0]           m_pos_x;
    logic signed [31:0]           m_pos_y;
    logic [31:0]                  m_pos_heading;

    pose_scoreboard pose_sb;
    int             tx_idle_pct;
    int             rx_idle_pct;
    longint         cycle_count;

    three_wheel_odometry_pose_update_core #(
        .COUNT_BITS  (COUNT_BITS),
        .CORDIC_STEPS(ARC_STEPS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_left_count  (s_left_count),
        .s_right_count (s_right_count),
        .s_back_count  (s_back_count),
        .s_load_x      (s_load_x),
        .s_load_y      (s_load_y),
        .s_load_heading(s_load_heading),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_pos_heading (m_pos_heading)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: end the run if the core stops making progress.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("three_wheel_odometry_pose_update_core_tb: done, errors");
            $finish;
        end
    end

    // Result side: check each accepted item, then pick the next ready level.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                pose_sb.check_pose(m_pos_x, m_pos_y, m_pos_heading);
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Write all four registers, one per cycle, and track them in the scoreboard.
    task automatic write_regs(logic [31:0] dpc, logic [31:0] lo, logic [31:0] ro,
                              logic [31:0] bo);
        logic [31:0] vals [4];
        logic [1:0]  idx;
        vals = '{dpc, lo, ro, bo};
        for (int i = 0; i < 4; i++) begin
            idx = 2'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            pose_sb.set_reg(idx, vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Hold off the sender until every predicted pose has been seen, then let
    // the core settle.
    task automatic drain();
        while (pose_sb.poses_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Present one item and hold it until accepted; keep valid high if the
    // next item follows at once, otherwise drop it here.
    task automatic send_item(logic mode, logic signed [COUNT_BITS-1:0] lc,
                             logic signed [COUNT_BITS-1:0] rc,
                             logic signed [COUNT_BITS-1:0] bc,
                             logic [31:0] lx, logic [31:0] ly, logic [31:0] lh);
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_left_count   <= lc;
        s_right_count  <= rc;
        s_back_count   <= bc;
        s_load_x       <= lx;
        s_load_y       <= ly;
        s_load_heading <= lh;
        do @(posedge aclk); while (!s_ready);
        pose_sb.note_item(mode, lc, rc, bc, lx, ly, lh);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic send_update(int lc, int rc, int bc);
        send_item(1'b0, lc[COUNT_BITS-1:0], rc[COUNT_BITS-1:0], bc[COUNT_BITS-1:0],
                  $urandom, $urandom, $urandom);
    endtask

    task automatic send_load(logic [31:0] lx, logic [31:0] ly, logic [31:0] lh);
        send_item(1'b1, COUNT_BITS'($urandom), COUNT_BITS'($urandom),
                  COUNT_BITS'($urandom), lx, ly, lh);
    endtask

    // Half realistic small deltas, half full-range deltas.
    function automatic int pick_count();
        if ($urandom_range(1))
            return $urandom_range(400) - 200;
        return int'(signed'(COUNT_BITS'($urandom)));
    endfunction

    task automatic directed_items();
        send_update(0, 0, 0);
        send_update(100, -100, 0);
        send_update(-100, 100, 50);
        send_update(200, 200, -200);
        send_update(32767, -32768, 32767);
        send_update(-32768, 32767, -32768);
        send_update(-32768, -32768, -32768);
        send_update(32767, 32767, 32767);
        send_update(-1, 1, -1);
        send_load(32'h7FFF_0000, 32'h8000_0000, 32'h4000_0000);
        send_update(32767, 32767, -32768);
        send_update(-32768, -32768, 32767);
        send_load(32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000);
        send_update(-32768, -32768, 32767);
        send_update(32767, 32767, -32768);
        send_load(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_update(30, 10, 5);
        send_load(32'h0, 32'h0, 32'h8000_0000);
        send_update(-300, 300, 0);
        send_update(12, 12, 0);
    endtask

    initial begin
        logic [31:0] regs [5][4];
        int          total;
        pose_sb = new();
        tx_idle_pct = 22;
        rx_idle_pct = 70;
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_DPC;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_mode         <= 1'b0;
        s_left_count   <= '0;
        s_right_count  <= '0;
        s_back_count   <= '0;
        s_load_x       <= '0;
        s_load_y       <= '0;
        s_load_heading <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register settings per phase: defaults, all at maximum, minimum scale with
        // zero offsets, a random mix, and left/right offsets summing to zero with the back offset at maximum.
        regs[0] = '{DPC_RESET, LOFF_RESET, ROFF_RESET, BOFF_RESET};
        regs[1] = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        regs[2] = '{32'd1, 32'd0, 32'd0, 32'd0};
        regs[3] = '{$urandom_range(32'h0100_0000, 1), {1'b0, 31'($urandom)} >> 8,
                    {1'b0, 31'($urandom)} >> 8, {1'b0, 31'($urandom)}};
        regs[4] = '{32'd402627, 32'd0, 32'd0, 32'h7FFF_FFFF};

        total = 0;
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                // Idle only once every pose is out: this is also the pause
                // where the sender waits for the result side to catch up.
                s_valid <= 1'b0;
                drain();
                write_regs(regs[ph][0], regs[ph][1], regs[ph][2], regs[ph][3]);
            end
            if (ph == 0) directed_items();
            for (int n = 0; n < 270; n++) begin
                // Swap the idling pattern a third of the way in, then stop it.
                if (total == 450) begin
                    tx_idle_pct = 70;
                    rx_idle_pct = 22;
                end else if (total == 900) begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                if ($urandom_range(9) == 0)
                    send_load($urandom, $urandom, $urandom);
                else
                    send_update(pick_count(), pick_count(), pick_count());
                total++;
            end
        end
        s_valid <= 1'b0;
        drain();

        $display("covered %0d items (%0d pose loads, %0d saturated turns), %0d results",
                 pose_sb.n_taken, pose_sb.n_loads, pose_sb.n_sat_turns, pose_sb.n_checked);
        $display("over five register settings and three idling patterns");
        if (pose_sb.n_errors == 0 && pose_sb.poses_due.size() == 0) begin
            $display("three_wheel_odometry_pose_update_core_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d results missing", pose_sb.n_errors,
                     pose_sb.poses_due.size());
            $display("three_wheel_odometry_pose_update_core_tb: done, errors");
        end
        $finish;
    end

endmodule
